FILE: src/rcat_pkg.sv
// ----------------------------------------------------------------------------
// rcat_pkg
// Shared types, codes and helpers of the reliable channel ack tracker.
// ----------------------------------------------------------------------------
package rcat_pkg;

  // Word and field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned OUT_DATA_W = 136;

  // Span of the acknowledgement window
  localparam logic [WORD_W-1:0] ACK_WINDOW = 32'd32;

  // Reset value of the disconnect timeout, microseconds
  localparam logic [WORD_W-1:0] TIMEOUT_RESET = 32'd5000000;

  typedef enum logic [1:0] {
    OP_RECEIVE   = 2'd0,
    OP_SEND      = 2'd1,
    OP_OPEN      = 2'd2,
    OP_SET_STATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CS_CONNECTING = 2'd0,
    CS_CONNECTED  = 2'd1,
    CS_TIMEOUT    = 2'd2,
    CS_DROPPING   = 2'd3
  } conn_state_e;

  typedef enum logic [2:0] {
    RSN_NONE        = 3'd0,
    RSN_DROPPING    = 3'd1,
    RSN_TIMED_OUT   = 3'd2,
    RSN_PEER_ACK    = 3'd3,
    RSN_TOO_OLD     = 3'd4,
    RSN_TOO_FAR     = 3'd5,
    RSN_BAD_REBIND  = 3'd6
  } reason_e;

  // Channel record
  typedef struct packed {
    logic [WORD_W-1:0] peer_addr;
    logic [PORT_W-1:0] peer_port;
    conn_state_e       conn_state;
    logic [TIME_W-1:0] last_heard;
    logic [WORD_W-1:0] next_seq;
    logic [WORD_W-1:0] highest_seq;
    logic [WORD_W-1:0] out_ack;
    logic [WORD_W-1:0] peer_ack;
  } rec_t;

  // One input word, unpacked
  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] now_time;
    logic [WORD_W-1:0] seq_num;
    logic [WORD_W-1:0] ack_bits;
    logic [WORD_W-1:0] peer_last_seq;
    logic [WORD_W-1:0] from_addr;
    logic [PORT_W-1:0] from_port;
    logic [1:0]        new_state;
  } item_t;

  // One result word, unpacked
  typedef struct packed {
    logic              accepted;
    reason_e           reason;
    logic              rebound;
    logic [WORD_W-1:0] seq_out;
    logic [WORD_W-1:0] ack_bits_out;
    logic [WORD_W-1:0] last_recv;
    logic [WORD_W-1:0] peer_acked;
    logic [1:0]        conn_state;
  } result_t;

  // Left shift that gives zero once the amount reaches the word width
  function automatic logic [WORD_W-1:0] shl_word(logic [WORD_W-1:0] v,
                                                 logic [WORD_W-1:0] n);
    logic [WORD_W-1:0] r;
    if (n >= WORD_W) begin
      r = '0;
    end else begin
      r = v << n[$clog2(WORD_W)-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/rcat_core.sv
// ----------------------------------------------------------------------------
// rcat_core
// Record update for one word: receive checks, send, open and set state.
// ----------------------------------------------------------------------------
module rcat_core (
  input  rcat_pkg::rec_t                    rec_i,
  input  rcat_pkg::item_t                   item_i,
  input  logic [rcat_pkg::WORD_W-1:0]       timeout_i,
  output rcat_pkg::rec_t                    rec_o,
  output rcat_pkg::result_t                 res_o
);
  import rcat_pkg::*;

  logic [TIME_W-1:0] silence;
  logic [WORD_W-1:0] seq_gap;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] plast_win;
  logic [WORD_W-1:0] seq_win;
  logic [WORD_W-1:0] high_win;
  logic              src_diff;

  // Derive the quantities the receive checks share
  always_comb begin
    silence   = item_i.now_time - rec_i.last_heard;
    seq_gap   = rec_i.next_seq - item_i.peer_last_seq;
    mask      = shl_word(32'd1, seq_gap) - 32'd1;
    plast_win = item_i.peer_last_seq + ACK_WINDOW;
    seq_win   = item_i.seq_num + ACK_WINDOW;
    high_win  = rec_i.highest_seq + ACK_WINDOW;
    src_diff  = (item_i.from_addr != rec_i.peer_addr) ||
                (item_i.from_port != rec_i.peer_port);
  end

  // Apply the operation to the record
  always_comb begin
    rec_o          = rec_i;
    res_o          = '0;
    res_o.accepted = 1'b1;
    res_o.reason   = RSN_NONE;
    unique case (item_i.op)
      OP_RECEIVE: begin
        priority if (rec_i.conn_state == CS_DROPPING) begin
          res_o.reason = RSN_DROPPING;
        end else if (rec_i.conn_state == CS_CONNECTED &&
                     silence > {{(TIME_W-WORD_W){1'b0}}, timeout_i}) begin
          res_o.reason = RSN_TIMED_OUT;
        end else if (plast_win < rec_i.next_seq ||
                     item_i.peer_last_seq > rec_i.next_seq) begin
          res_o.reason = RSN_PEER_ACK;
        end else if (seq_win < rec_i.highest_seq) begin
          res_o.reason = RSN_TOO_OLD;
        end else if (item_i.seq_num > high_win) begin
          res_o.reason = RSN_TOO_FAR;
        end else if (src_diff &&
                     ((item_i.ack_bits & ~mask) != '0 ||
                      (rec_i.next_seq != '0 && (item_i.ack_bits & mask) == '0))) begin
          res_o.reason = RSN_BAD_REBIND;
        end else begin
          // Rebind to the new source
          if (src_diff) begin
            rec_o.peer_addr  = item_i.from_addr;
            rec_o.peer_port  = item_i.from_port;
            rec_o.conn_state = CS_CONNECTED;
            res_o.rebound    = 1'b1;
          end
          // Slide or mark the outgoing ack bits
          if (item_i.seq_num >= rec_i.highest_seq) begin
            rec_o.out_ack = shl_word(rec_i.out_ack, item_i.seq_num - rec_i.highest_seq)
                            | 32'd1;
            rec_o.highest_seq = item_i.seq_num;
          end else begin
            rec_o.out_ack = rec_i.out_ack |
                            shl_word(32'd1, rec_i.highest_seq - item_i.seq_num);
          end
          rec_o.last_heard = item_i.now_time;
          rec_o.peer_ack   = rec_i.peer_ack | shl_word(item_i.ack_bits, seq_gap) |
                             shl_word(32'd1, seq_gap);
        end
        res_o.accepted = (res_o.reason == RSN_NONE);
      end
      OP_SEND: begin
        res_o.seq_out  = rec_i.next_seq;
        rec_o.next_seq = rec_i.next_seq + 32'd1;
      end
      OP_OPEN: begin
        rec_o.peer_addr   = item_i.from_addr;
        rec_o.peer_port   = item_i.from_port;
        rec_o.conn_state  = CS_CONNECTING;
        rec_o.last_heard  = item_i.now_time;
        rec_o.next_seq    = '0;
        rec_o.highest_seq = '0;
        rec_o.out_ack     = '0;
        rec_o.peer_ack    = '0;
      end
      OP_SET_STATE: begin
        rec_o.conn_state = conn_state_e'(item_i.new_state);
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
    res_o.ack_bits_out = rec_o.out_ack;
    res_o.last_recv    = rec_o.highest_seq;
    res_o.peer_acked   = rec_o.peer_ack;
    res_o.conn_state   = rec_o.conn_state;
  end

endmodule

FILE: src/reliable_channel_ack_tracker_unit.sv
// ----------------------------------------------------------------------------
// reliable_channel_ack_tracker_unit
// Ack and sequence record of one reliable channel, one operation per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_axis group; tuser carries the operation
//   (receive, send, open, set state) and tdata the header fields. Each
//   input word yields exactly one result word on the m_axis group, carrying
//   the verdict, reject reason, rebind flag, the sequence handed out and the
//   record's ack fields after the operation.
//   An accepted input word is loaded into the input register; the record
//   update is then written into the result register, from which the
//   result can be taken.
//   Throughput is one word per cycle while the receiver takes results; the record
//   is written with the result, so the next word always sees the updated record.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; tready drops only once both are occupied.
//   Reset clears the record (state connecting) and sets the disconnect
//   timeout to 5000000 us. Write the timeout through cfg_we_i/cfg_wdata_i
//   while no word is in flight.
// ----------------------------------------------------------------------------
module reliable_channel_ack_tracker_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: disconnect timeout
  input  logic                              cfg_we_i,
  input  logic [rcat_pkg::WORD_W-1:0]       cfg_wdata_i,
  // Input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata, low bit up: now_time[47:0], seq_num[79:48], ack_bits_in[111:80],
  // peer_last_seq[143:112], from_addr[175:144], from_port[191:176],
  // new_state[193:192], zero pad[199:194]
  input  logic [rcat_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: operation[1:0]
  input  logic [1:0]                        s_axis_tuser_i,
  // Output stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata, low bit up: accepted[0], reject_reason[3:1], rebound[4],
  // seq_out[36:5], ack_bits_out[68:37], last_recv_out[100:69],
  // peer_acked_bits[132:101], conn_state_out[134:133], zero pad[135]
  output logic [rcat_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import rcat_pkg::*;

  item_t             item_d, item_q;
  logic              in_vld_q;
  result_t           res_d, res_q;
  logic              out_vld_q;
  rec_t              rec_d, rec_q;
  logic [WORD_W-1:0] timeout_q;
  logic              advance;

  // Unpack the incoming word
  always_comb begin
    item_d.op            = op_e'(s_axis_tuser_i);
    item_d.now_time      = s_axis_tdata_i[47:0];
    item_d.seq_num       = s_axis_tdata_i[79:48];
    item_d.ack_bits      = s_axis_tdata_i[111:80];
    item_d.peer_last_seq = s_axis_tdata_i[143:112];
    item_d.from_addr     = s_axis_tdata_i[175:144];
    item_d.from_port     = s_axis_tdata_i[191:176];
    item_d.new_state     = s_axis_tdata_i[193:192];
  end

  // Move the held word into the result register when that slot frees up
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  rcat_core u_core (
    .rec_i     (rec_q),
    .item_i    (item_q),
    .timeout_i (timeout_q),
    .rec_o     (rec_d),
    .res_o     (res_d)
  );

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Advance the record on each processed word; all zero is state connecting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (advance) begin
      rec_q <= rec_d;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q <= item_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Pack the result word
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, res_q.conn_state, res_q.peer_acked, res_q.last_recv,
                            res_q.ack_bits_out, res_q.seq_out, res_q.rebound,
                            res_q.reason, res_q.accepted};

endmodule
